>>> rtl/core/latlon_to_dms_split_assert.svh
// assertion macros for the lat/lon to dms splitter
`ifndef LATLON_TO_DMS_SPLIT_ASSERT_SVH
`define LATLON_TO_DMS_SPLIT_ASSERT_SVH

`ifndef SYNTHESIS
`define LLDMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lldms assertion failed");
`define LLDMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lldms assertion failed");
`else
`define LLDMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LLDMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/lldms_pkg.sv
// shared constants, types and tables for the lat/lon to dms splitter
`default_nettype none

package lldms_pkg;

    // fixed-point format of angles
    localparam int FRAC_BITS  = 24;
    localparam int IN_W       = 35;
    // working width of the fold arithmetic, holds +-1260 degrees and the input
    localparam int NORM_W     = (IN_W + 2 > FRAC_BITS + 13) ? IN_W + 2 : FRAC_BITS + 13;
    // minutes and seconds before masking: below 64 whole units
    localparam int MIN_W      = FRAC_BITS + 6;
    localparam int P10_W      = 24;
    localparam int LIM_W      = 30;
    localparam int PROD_W     = MIN_W + P10_W;

    localparam int LAT_DEG_W  = 31;
    localparam int LON_DEG_W  = 32;
    localparam int MIN_OUT_W  = 30;
    localparam int SEC_OUT_W  = 30;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam int DEC_W      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MINUTES_ON  = 2'd0,
        CFG_SECONDS_ON  = 2'd1,
        CFG_SECONDS_DEC = 2'd2
    } cfg_index_t;

    localparam logic [DEC_W-1:0] SECONDS_DEC_RESET = 3'd3;

    // degree constants in working format
    localparam logic signed [NORM_W-1:0] DEG_90   = NORM_W'(90)   << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_180  = NORM_W'(180)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_270  = NORM_W'(270)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_360  = NORM_W'(360)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_540  = NORM_W'(540)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_630  = NORM_W'(630)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_720  = NORM_W'(720)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_900  = NORM_W'(900)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_990  = NORM_W'(990)  << FRAC_BITS;
    localparam logic signed [NORM_W-1:0] DEG_1080 = NORM_W'(1080) << FRAC_BITS;

    localparam logic [NORM_W-1:0]    ONE_DEG    = NORM_W'(1) << FRAC_BITS;
    localparam logic [MIN_W-1:0]     ONE_MIN    = MIN_W'(1) << FRAC_BITS;
    localparam logic [MIN_W-1:0]     SIXTY_MIN  = MIN_W'(60) << FRAC_BITS;
    localparam logic [PROD_W:0]      ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

    localparam logic [LAT_DEG_W-1:0] LAT_DEG_LIMIT = LAT_DEG_W'(90) << FRAC_BITS;
    localparam logic [MIN_OUT_W-1:0] MIN_OUT_LIMIT = MIN_OUT_W'(60) << FRAC_BITS;

    typedef struct packed {
        logic             minutes_on;
        logic             seconds_on;
        logic [DEC_W-1:0] seconds_decimals;
    } cfg_t;

    // per-stage load enables
    typedef struct packed {
        logic n1;
        logic n2;
        logic l1;
        logic l2;
        logic out;
    } pipe_en_t;

    typedef struct packed {
        logic              neg;
        logic [NORM_W-1:0] deg;
        logic [MIN_W-1:0]  min;
        logic [MIN_W-1:0]  sec;
    } lane_res_t;

    typedef struct packed {
        logic                 lat_negative;
        logic [LAT_DEG_W-1:0] lat_degrees;
        logic [MIN_OUT_W-1:0] lat_minutes;
        logic [SEC_OUT_W-1:0] lat_seconds;
        logic                 lon_negative;
        logic [LON_DEG_W-1:0] lon_degrees;
        logic [MIN_OUT_W-1:0] lon_minutes;
        logic [SEC_OUT_W-1:0] lon_seconds;
        logic                 format_error;
    } dms_result_t;

    // decimal scale for the round-to-sixty check
    function automatic logic [P10_W-1:0] pow10(input logic [DEC_W-1:0] d);
        logic [P10_W-1:0] p;
        case (d)
            3'd0:    p = 24'd1;
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            default: p = 24'd10000000;
        endcase
        return p;
    endfunction

    // sixty seconds at the same scale
    function automatic logic [LIM_W-1:0] sixty_pow10(input logic [DEC_W-1:0] d);
        logic [LIM_W-1:0] l;
        case (d)
            3'd0:    l = 30'd60;
            3'd1:    l = 30'd600;
            3'd2:    l = 30'd6000;
            3'd3:    l = 30'd60000;
            3'd4:    l = 30'd600000;
            3'd5:    l = 30'd6000000;
            3'd6:    l = 30'd60000000;
            default: l = 30'd600000000;
        endcase
        return l;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lldms_ifs.sv
// valid/ready channel interfaces for coordinate input and dms result
`default_nettype none

interface lldms_coord_if import lldms_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] lat_angle;
    logic signed [IN_W-1:0] lon_angle;

    modport source (output valid, output lat_angle, output lon_angle, input ready);
    modport sink   (input valid, input lat_angle, input lon_angle, output ready);
endinterface

interface lldms_dms_if import lldms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 lat_negative;
    logic [LAT_DEG_W-1:0] lat_degrees;
    logic [MIN_OUT_W-1:0] lat_minutes;
    logic [SEC_OUT_W-1:0] lat_seconds;
    logic                 lon_negative;
    logic [LON_DEG_W-1:0] lon_degrees;
    logic [MIN_OUT_W-1:0] lon_minutes;
    logic [SEC_OUT_W-1:0] lon_seconds;
    logic                 format_error;

    modport source (
        output valid, output lat_negative, output lat_degrees, output lat_minutes,
        output lat_seconds, output lon_negative, output lon_degrees, output lon_minutes,
        output lon_seconds, output format_error, input ready
    );
    modport sink (
        input valid, input lat_negative, input lat_degrees, input lat_minutes,
        input lat_seconds, input lon_negative, input lon_degrees, input lon_minutes,
        input lon_seconds, input format_error, output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/lldms_norm.sv
// two-stage angle normalisation: latitude pole fold, then longitude wrap
`default_nettype none

module lldms_norm import lldms_pkg::*; (
    input  wire                       clk,
    input  wire pipe_en_t             en,
    input  wire logic signed [IN_W-1:0]   lat_angle,
    input  wire logic signed [IN_W-1:0]   lon_angle,
    output logic signed [NORM_W-1:0]  lat_norm,
    output logic signed [NORM_W-1:0]  lon_norm
);

    logic signed [NORM_W-1:0] lat_x;
    logic signed [NORM_W-1:0] lat_w;
    logic signed [NORM_W-1:0] lat_f;
    logic signed [NORM_W-1:0] lon_x;
    logic signed [NORM_W-1:0] lon_s;
    logic                     flip;
    logic signed [NORM_W-1:0] lon_w;

    logic signed [NORM_W-1:0] s1_lat_reg;
    logic signed [NORM_W-1:0] s1_lon_reg;
    logic signed [NORM_W-1:0] s2_lat_reg;
    logic signed [NORM_W-1:0] s2_lon_reg;

    // stage 1: latitude into [-270,270], then over the pole
    always_comb
    begin
        lat_x = NORM_W'(lat_angle);
        lon_x = NORM_W'(lon_angle);
        if (lat_x > DEG_990)
            lat_w = lat_x - DEG_1080;
        else if (lat_x > DEG_630)
            lat_w = lat_x - DEG_720;
        else if (lat_x > DEG_270)
            lat_w = lat_x - DEG_360;
        else if (lat_x < -DEG_990)
            lat_w = lat_x + DEG_1080;
        else if (lat_x < -DEG_630)
            lat_w = lat_x + DEG_720;
        else if (lat_x < -DEG_270)
            lat_w = lat_x + DEG_360;
        else
            lat_w = lat_x;

        flip  = 1'b0;
        lat_f = lat_w;
        if (lat_w > DEG_90)
        begin
            lat_f = DEG_180 - lat_w;
            flip  = 1'b1;
        end
        else if (lat_w < -DEG_90)
        begin
            lat_f = -DEG_180 - lat_w;
            flip  = 1'b1;
        end
        lon_s = flip ? lon_x + DEG_180 : lon_x;
    end

    // stage 2: longitude into [-180,180]
    always_comb
    begin
        if (s1_lon_reg > DEG_900)
            lon_w = s1_lon_reg - DEG_1080;
        else if (s1_lon_reg > DEG_540)
            lon_w = s1_lon_reg - DEG_720;
        else if (s1_lon_reg > DEG_180)
            lon_w = s1_lon_reg - DEG_360;
        else if (s1_lon_reg < -DEG_900)
            lon_w = s1_lon_reg + DEG_1080;
        else if (s1_lon_reg < -DEG_540)
            lon_w = s1_lon_reg + DEG_720;
        else if (s1_lon_reg < -DEG_180)
            lon_w = s1_lon_reg + DEG_360;
        else
            lon_w = s1_lon_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.n1)
        begin
            s1_lat_reg <= lat_f;
            s1_lon_reg <= lon_s;
        end
        if (en.n2)
        begin
            s2_lat_reg <= s1_lat_reg;
            s2_lon_reg <= lon_w;
        end
    end

    assign lat_norm = s2_lat_reg;
    assign lon_norm = s2_lon_reg;

endmodule

`default_nettype wire

>>> rtl/core/lldms_lane.sv
// one splitting lane: sign, degrees, minutes, seconds and the sixty carry
`default_nettype none

module lldms_lane import lldms_pkg::*; (
    input  wire                          clk,
    input  wire pipe_en_t                en,
    input  wire cfg_t                    cfg,
    input  wire logic signed [NORM_W-1:0]  angle,
    output lane_res_t                    res
);

    logic                     neg;
    logic [NORM_W-1:0]        mag;
    logic [MIN_W-1:0]         frac_x;
    logic [MIN_W-1:0]         min_full;
    logic [MIN_W-1:0]         mfrac_x;
    logic [MIN_W-1:0]         sec_full;
    logic                     split_sec;
    logic [NORM_W-1:0]        deg1;
    logic [MIN_W-1:0]         min1;
    logic [MIN_W-1:0]         sec1;

    logic                     s1_neg_reg;
    logic [NORM_W-1:0]        s1_deg_reg;
    logic [MIN_W-1:0]         s1_min_reg;
    logic [MIN_W-1:0]         s1_sec_reg;

    logic [PROD_W-1:0]        prod;
    logic                     s2_neg_reg;
    logic [NORM_W-1:0]        s2_deg_reg;
    logic [MIN_W-1:0]         s2_min_reg;
    logic [MIN_W-1:0]         s2_sec_reg;
    logic [PROD_W-1:0]        s2_prod_reg;

    logic [PROD_W:0]          rnd_sum;
    logic [PROD_W:0]          rnd_lim;
    logic [MIN_W-1:0]         min_inc;

    // stage 1: magnitude and the two times-sixty splits (shift and subtract)
    always_comb
    begin
        neg       = angle[NORM_W-1];
        mag       = neg ? $unsigned(-angle) : $unsigned(angle);
        frac_x    = MIN_W'(mag[FRAC_BITS-1:0]);
        min_full  = (frac_x << 6) - (frac_x << 2);
        mfrac_x   = MIN_W'(min_full[FRAC_BITS-1:0]);
        sec_full  = (mfrac_x << 6) - (mfrac_x << 2);
        split_sec = cfg.minutes_on & cfg.seconds_on;

        deg1 = mag;
        min1 = '0;
        sec1 = '0;
        if (cfg.minutes_on)
        begin
            deg1 = {mag[NORM_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
            min1 = min_full;
            if (split_sec)
            begin
                min1 = {min_full[MIN_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
                sec1 = sec_full;
            end
        end
    end

    // stage 2: seconds scaled by the decimal factor
    assign prod = PROD_W'(s1_sec_reg) * PROD_W'(pow10(cfg.seconds_decimals));

    // stage 3: rounding check; seconds are zero when not split, so no carry then
    always_comb
    begin
        rnd_sum = (PROD_W + 1)'(s2_prod_reg) + ROUND_HALF;
        rnd_lim = (PROD_W + 1)'(sixty_pow10(cfg.seconds_decimals)) << FRAC_BITS;
        min_inc = s2_min_reg + ONE_MIN;

        res.neg = s2_neg_reg;
        res.deg = s2_deg_reg;
        res.min = s2_min_reg;
        res.sec = s2_sec_reg;
        if (rnd_sum >= rnd_lim)
        begin
            res.sec = '0;
            if (min_inc >= SIXTY_MIN)
            begin
                res.min = '0;
                res.deg = s2_deg_reg + ONE_DEG;
            end
            else
                res.min = min_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.l1)
        begin
            s1_neg_reg <= neg;
            s1_deg_reg <= deg1;
            s1_min_reg <= min1;
            s1_sec_reg <= sec1;
        end
        if (en.l2)
        begin
            s2_neg_reg  <= s1_neg_reg;
            s2_deg_reg  <= s1_deg_reg;
            s2_min_reg  <= s1_min_reg;
            s2_sec_reg  <= s1_sec_reg;
            s2_prod_reg <= prod;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lldms_merge.sv
// output register joining both lanes and the format flag
`default_nettype none

module lldms_merge import lldms_pkg::*; (
    input  wire               clk,
    input  wire pipe_en_t     en,
    input  wire cfg_t         cfg,
    input  wire lane_res_t    lat_res,
    input  wire lane_res_t    lon_res,
    output dms_result_t       result
);

    dms_result_t result_next;
    dms_result_t result_reg;

    always_comb
    begin
        result_next.lat_negative = lat_res.neg;
        result_next.lat_degrees  = LAT_DEG_W'(lat_res.deg);
        result_next.lat_minutes  = MIN_OUT_W'(lat_res.min);
        result_next.lat_seconds  = SEC_OUT_W'(lat_res.sec);
        result_next.lon_negative = lon_res.neg;
        result_next.lon_degrees  = LON_DEG_W'(lon_res.deg);
        result_next.lon_minutes  = MIN_OUT_W'(lon_res.min);
        result_next.lon_seconds  = SEC_OUT_W'(lon_res.sec);
        result_next.format_error = cfg.seconds_on & ~cfg.minutes_on;
    end

    always_ff @(posedge clk)
    begin
        if (en.out)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/latlon_to_dms_split.sv
// top level of the lat/lon to degrees-minutes-seconds splitter
//
//  channel    dir   handshake     payload
//  coord_in   in    valid/ready   lat_angle, lon_angle (signed, 24 fraction bits)
//  dms_out    out   valid/ready   sign, degrees, minutes, seconds per axis, format_error
//  cfg        in    cfg_wr_en     cfg_index, cfg_wr_data (no read-back)
//
// one coordinate pair per cycle unless dms_out stalls; each pair passes the stages below in order to result valid
// stages: latitude fold, longitude wrap, lane split, lane scale multiply, output register
// the seconds-times-decimal-scale multiplier in each lane sets the stage depth
// each stage holds while its successor is full and stalled, so a bubble anywhere
//   lets input transfers continue while a result waits at the output
// reset clears the valid bits and loads minutes on, seconds on, three decimals
`default_nettype none

`include "latlon_to_dms_split_assert.svh"

module latlon_to_dms_split import lldms_pkg::*; (
    input  wire                          clk,
    input  wire                          rst_n,
    lldms_coord_if.sink                  coord_in,
    lldms_dms_if.source                  dms_out,
    input  wire                          cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wr_data
);

    // configuration registers
    cfg_t cfg_reg;

    // pipeline occupancy
    logic n1_valid_reg;
    logic n2_valid_reg;
    logic l1_valid_reg;
    logic l2_valid_reg;
    logic out_valid_reg;

    logic rdy_n1;
    logic rdy_n2;
    logic rdy_l1;
    logic rdy_l2;
    logic rdy_out;

    pipe_en_t                  pipe_en;
    logic signed [NORM_W-1:0]  lat_norm;
    logic signed [NORM_W-1:0]  lon_norm;
    lane_res_t                 lat_res;
    lane_res_t                 lon_res;
    dms_result_t               result;

    // register writes; index three is unused and ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.minutes_on       <= 1'b1;
            cfg_reg.seconds_on       <= 1'b1;
            cfg_reg.seconds_decimals <= SECONDS_DEC_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MINUTES_ON:  cfg_reg.minutes_on       <= cfg_wr_data[0];
                CFG_SECONDS_ON:  cfg_reg.seconds_on       <= cfg_wr_data[0];
                CFG_SECONDS_DEC: cfg_reg.seconds_decimals <= cfg_wr_data[DEC_W-1:0];
                default: ;
            endcase
        end
    end

    // ready ripples back from the output: a stage loads when empty or draining
    always_comb
    begin
        rdy_out = ~out_valid_reg | dms_out.ready;
        rdy_l2  = ~l2_valid_reg  | rdy_out;
        rdy_l1  = ~l1_valid_reg  | rdy_l2;
        rdy_n2  = ~n2_valid_reg  | rdy_l1;
        rdy_n1  = ~n1_valid_reg  | rdy_n2;

        pipe_en.n1  = rdy_n1  & coord_in.valid;
        pipe_en.n2  = rdy_n2  & n1_valid_reg;
        pipe_en.l1  = rdy_l1  & n2_valid_reg;
        pipe_en.l2  = rdy_l2  & l1_valid_reg;
        pipe_en.out = rdy_out & l2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_valid_reg  <= 1'b0;
            n2_valid_reg  <= 1'b0;
            l1_valid_reg  <= 1'b0;
            l2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_n1)
                n1_valid_reg <= coord_in.valid;
            if (rdy_n2)
                n2_valid_reg <= n1_valid_reg;
            if (rdy_l1)
                l1_valid_reg <= n2_valid_reg;
            if (rdy_l2)
                l2_valid_reg <= l1_valid_reg;
            if (rdy_out)
                out_valid_reg <= l2_valid_reg;
        end
    end

    assign coord_in.ready = rdy_n1;

    // normalisation of the pair (latitude fold couples into longitude)
    lldms_norm u_norm (
        .clk       (clk),
        .en        (pipe_en),
        .lat_angle (coord_in.lat_angle),
        .lon_angle (coord_in.lon_angle),
        .lat_norm  (lat_norm),
        .lon_norm  (lon_norm)
    );

    // one splitting lane per axis, running side by side
    lldms_lane u_lane_lat (
        .clk   (clk),
        .en    (pipe_en),
        .cfg   (cfg_reg),
        .angle (lat_norm),
        .res   (lat_res)
    );

    lldms_lane u_lane_lon (
        .clk   (clk),
        .en    (pipe_en),
        .cfg   (cfg_reg),
        .angle (lon_norm),
        .res   (lon_res)
    );

    // lanes joined into the output register
    lldms_merge u_merge (
        .clk     (clk),
        .en      (pipe_en),
        .cfg     (cfg_reg),
        .lat_res (lat_res),
        .lon_res (lon_res),
        .result  (result)
    );

    assign dms_out.valid        = out_valid_reg;
    assign dms_out.lat_negative = result.lat_negative;
    assign dms_out.lat_degrees  = result.lat_degrees;
    assign dms_out.lat_minutes  = result.lat_minutes;
    assign dms_out.lat_seconds  = result.lat_seconds;
    assign dms_out.lon_negative = result.lon_negative;
    assign dms_out.lon_degrees  = result.lon_degrees;
    assign dms_out.lon_minutes  = result.lon_minutes;
    assign dms_out.lon_seconds  = result.lon_seconds;
    assign dms_out.format_error = result.format_error;

    // a folded latitude never passes the pole, even after a carry
    `LLDMS_ASSERT_IMPL(a_lat_in_range, clk, rst_n, dms_out.valid, dms_out.lat_degrees <= LAT_DEG_LIMIT)
    // a format error leaves minutes and seconds empty
    `LLDMS_ASSERT_IMPL(a_fmt_err_no_split, clk, rst_n, dms_out.valid && dms_out.format_error, dms_out.lat_minutes == '0 && dms_out.lon_minutes == '0 && dms_out.lat_seconds == '0 && dms_out.lon_seconds == '0)
    // minutes stay below sixty after the carry
    `LLDMS_ASSERT_IMPL(a_min_below_sixty, clk, rst_n, dms_out.valid && cfg_reg.seconds_on, dms_out.lat_minutes < MIN_OUT_LIMIT && dms_out.lon_minutes < MIN_OUT_LIMIT)
    // a full multiply stage moves into a free output register
    `LLDMS_ASSERT_NEXT(a_l2_to_out, clk, rst_n, l2_valid_reg && rdy_out, out_valid_reg)

endmodule

`default_nettype wire
